### src/pif_pkg.sv
// Shared types and constants for the printf-style integer formatter.
package pif_pkg;

   // Conversion codes carried on the request channel.
   localparam logic [1:0] CONV_DEC       = 2'd0;
   localparam logic [1:0] CONV_HEX_LOWER = 2'd1;
   localparam logic [1:0] CONV_HEX_UPPER = 2'd2;

   // Field widths and limits.
   localparam int unsigned MAG_BITS    = 64;
   localparam int unsigned NUM_DIGITS  = 20;
   localparam int unsigned DIGIT_BITS  = NUM_DIGITS * 4;
   localparam int unsigned ND_BITS     = $clog2(NUM_DIGITS + 1);
   localparam int unsigned LEN_BITS    = 6;
   localparam int unsigned CHARS_BITS  = 32;
   localparam logic [LEN_BITS-1:0] MAX_FIELD = 6'd56;

   // ASCII characters used in the output text.
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_X_LOWER   = 8'h78;
   localparam logic [7:0] CHAR_X_UPPER   = 8'h58;
   localparam logic [7:0] HEX_LOWER_BIAS = 8'd87;
   localparam logic [7:0] HEX_UPPER_BIAS = 8'd55;

   // One request: a value with its printf flags.
   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         conversion;
      logic               left_justify;
      logic               zero_pad;
      logic               has_precision;
      logic               force_plus;
      logic               space_sign;
      logic               alt_prefix;
      logic [5:0]         field_width;
      logic [5:0]         precision_digits;
   } pif_req_type;

   // One response: a single output character.
   typedef struct packed {
      logic [7:0]  out_char;
      logic        last_char;
      logic [31:0] chars_so_far;
   } pif_rsp_type;

   // A converted value with its text layout, passed from front to back.
   // The e_* fields are the end positions of each region of the text.
   typedef struct packed {
      logic [DIGIT_BITS-1:0] digits;
      logic [LEN_BITS-1:0]   e_lead;
      logic [LEN_BITS-1:0]   e_pfx;
      logic [LEN_BITS-1:0]   e_sign;
      logic [LEN_BITS-1:0]   e_zpad;
      logic [LEN_BITS-1:0]   e_prec;
      logic [LEN_BITS-1:0]   e_dig;
      logic [LEN_BITS-1:0]   e_total;
      logic [7:0]            sign_char;
      logic                  upper;
   } pif_job_type;

endpackage

### src/pif_front.sv
// Front end: accepts a request, converts the magnitude to digits and lays out the text.
module pif_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pif_pkg::pif_req_type req_data,
   output logic                 push,
   input  logic                 full,
   output pif_pkg::pif_job_type job
);

   localparam int unsigned ITER_BITS = $clog2(pif_pkg::MAG_BITS);

   typedef enum logic [5:0] {
      F_IDLE   = 6'b000001,
      F_CONV   = 6'b000010,
      F_COUNT  = 6'b000100,
      F_LAYOUT = 6'b001000,
      F_PAD    = 6'b010000,
      F_PUSH   = 6'b100000
   } front_state_type;

   front_state_type                  state_ff, state_in;
   logic [pif_pkg::MAG_BITS-1:0]     mag_ff, mag_in;
   logic [pif_pkg::DIGIT_BITS-1:0]   bcd_ff, bcd_in;
   logic [ITER_BITS-1:0]             iter_ff, iter_in;
   logic [pif_pkg::ND_BITS-1:0]      nd_ff, nd_in;
   logic [pif_pkg::LEN_BITS-1:0]     zeros_ff, zeros_in;
   logic [pif_pkg::LEN_BITS-1:0]     pad_ff, pad_in;
   logic [pif_pkg::LEN_BITS-1:0]     width_ff, width_in;
   logic [pif_pkg::LEN_BITS-1:0]     prec_ff, prec_in;
   logic [7:0]                       sign_ff, sign_in;
   logic                             has_sign_ff, has_sign_in;
   logic                             prefix_ff, prefix_in;
   logic                             upper_ff, upper_in;
   logic                             left_ff, left_in;
   logic                             zfill_ff, zfill_in;

   logic                             accept;
   logic                             neg;
   logic                             is_hex;
   logic [pif_pkg::MAG_BITS-1:0]     abs_val;
   logic [pif_pkg::DIGIT_BITS-1:0]   bcd_adj;
   logic [pif_pkg::ND_BITS-1:0]      nd_calc;
   logic [pif_pkg::LEN_BITS:0]       body;
   logic [pif_pkg::LEN_BITS-1:0]     lead_len;
   logic [pif_pkg::LEN_BITS-1:0]     zpad_len;
   logic [pif_pkg::LEN_BITS-1:0]     trail_len;

   assign req_ready = (state_ff == F_IDLE);
   assign accept    = req_valid && req_ready;

   // Classify the incoming request.
   assign neg     = req_data.value[63];
   assign abs_val = neg ? (64'd0 - req_data.value) : req_data.value;
   assign is_hex  = (req_data.conversion == pif_pkg::CONV_HEX_LOWER) ||
                    (req_data.conversion == pif_pkg::CONV_HEX_UPPER);

   // Double-dabble correction: every BCD digit of five or more gets three added.
   always_comb begin
      for (int i = 0; i < pif_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // Digit count: position of the highest nonzero digit, at least one.
   always_comb begin
      nd_calc = pif_pkg::ND_BITS'(1);
      for (int i = 0; i < pif_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            nd_calc = pif_pkg::ND_BITS'(i + 1);
         end
      end
   end

   // Text length before padding.
   always_comb begin
      body = (pif_pkg::LEN_BITS+1)'(nd_ff) + (pif_pkg::LEN_BITS+1)'(zeros_ff) +
             (pif_pkg::LEN_BITS+1)'(has_sign_ff) +
             (prefix_ff ? (pif_pkg::LEN_BITS+1)'(2) : '0);
   end

   // Region lengths and end positions of the laid-out text.
   assign lead_len  = (!left_ff && !zfill_ff) ? pad_ff : '0;
   assign zpad_len  = zfill_ff ? pad_ff : '0;
   assign trail_len = left_ff ? pad_ff : '0;

   always_comb begin
      job.digits    = bcd_ff;
      job.e_lead    = lead_len;
      job.e_pfx     = job.e_lead + (prefix_ff ? pif_pkg::LEN_BITS'(2) : '0);
      job.e_sign    = job.e_pfx + pif_pkg::LEN_BITS'(has_sign_ff);
      job.e_zpad    = job.e_sign + zpad_len;
      job.e_prec    = job.e_zpad + zeros_ff;
      job.e_dig     = job.e_prec + pif_pkg::LEN_BITS'(nd_ff);
      job.e_total   = job.e_dig + trail_len;
      job.sign_char = sign_ff;
      job.upper     = upper_ff;
   end

   assign push = (state_ff == F_PUSH) && !full;

   // Sequencer: convert (decimal only), count, lay out, size the padding, then hand the job over.
   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      iter_in     = iter_ff;
      nd_in       = nd_ff;
      zeros_in    = zeros_ff;
      pad_in      = pad_ff;
      width_in    = width_ff;
      prec_in     = prec_ff;
      sign_in     = sign_ff;
      has_sign_in = has_sign_ff;
      prefix_in   = prefix_ff;
      upper_in    = upper_ff;
      left_in     = left_ff;
      zfill_in    = zfill_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               mag_in   = abs_val;
               iter_in  = '0;
               width_in = (req_data.field_width > pif_pkg::MAX_FIELD) ?
                          pif_pkg::MAX_FIELD : req_data.field_width;
               if (!req_data.has_precision) begin
                  prec_in = '0;
               end else if (req_data.precision_digits > pif_pkg::MAX_FIELD) begin
                  prec_in = pif_pkg::MAX_FIELD;
               end else begin
                  prec_in = req_data.precision_digits;
               end
               has_sign_in = neg || req_data.force_plus || req_data.space_sign;
               if (neg) begin
                  sign_in = pif_pkg::CHAR_MINUS;
               end else if (req_data.force_plus) begin
                  sign_in = pif_pkg::CHAR_PLUS;
               end else begin
                  sign_in = pif_pkg::CHAR_SPACE;
               end
               prefix_in = is_hex && req_data.alt_prefix && (abs_val != '0);
               upper_in  = (req_data.conversion == pif_pkg::CONV_HEX_UPPER);
               left_in   = req_data.left_justify;
               zfill_in  = !req_data.left_justify && req_data.zero_pad &&
                           !req_data.has_precision;
               if (is_hex) begin
                  bcd_in   = pif_pkg::DIGIT_BITS'(abs_val);
                  state_in = F_COUNT;
               end else begin
                  bcd_in   = '0;
                  state_in = F_CONV;
               end
            end
         end
         F_CONV: begin
            bcd_in  = {bcd_adj[pif_pkg::DIGIT_BITS-2:0], mag_ff[pif_pkg::MAG_BITS-1]};
            mag_in  = {mag_ff[pif_pkg::MAG_BITS-2:0], 1'b0};
            iter_in = iter_ff + ITER_BITS'(1);
            if (iter_ff == {ITER_BITS{1'b1}}) begin
               state_in = F_COUNT;
            end
         end
         F_COUNT: begin
            nd_in    = nd_calc;
            state_in = F_LAYOUT;
         end
         F_LAYOUT: begin
            zeros_in = (prec_ff > pif_pkg::LEN_BITS'(nd_ff)) ?
                       (prec_ff - pif_pkg::LEN_BITS'(nd_ff)) : '0;
            state_in = F_PAD;
         end
         F_PAD: begin
            pad_in = ((pif_pkg::LEN_BITS+1)'(width_ff) > body) ?
                     (width_ff - body[pif_pkg::LEN_BITS-1:0]) : '0;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // The pad register is written in its own state, so every field of the job
   // is settled by the time the hand-over state is entered.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      iter_ff     <= iter_in;
      nd_ff       <= nd_in;
      zeros_ff    <= zeros_in;
      pad_ff      <= pad_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      sign_ff     <= sign_in;
      has_sign_ff <= has_sign_in;
      prefix_ff   <= prefix_in;
      upper_ff    <= upper_in;
      left_ff     <= left_in;
      zfill_ff    <= zfill_in;
   end

endmodule

### src/pif_fifo.sv
// Two-entry job queue between the converter and the character emitter.
module pif_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pif_pkg::pif_job_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output pif_pkg::pif_job_type head
);

   localparam int unsigned DEPTH     = 2;
   localparam int unsigned PTR_BITS  = $clog2(DEPTH);
   localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

   pif_pkg::pif_job_type  entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + PTR_BITS'(1)) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/pif_back.sv
// Back end: emits the head job's laid-out text, one character per cycle unless stalled.
module pif_back #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  pif_pkg::pif_job_type job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pif_pkg::pif_rsp_type rsp_data
);

   logic [pif_pkg::LEN_BITS-1:0] pos_ff, pos_in;
   logic [COUNT_BITS-1:0]        total_ff, total_in;
   logic                         valid_ff, valid_in;
   pif_pkg::pif_rsp_type         data_ff, data_in;

   logic                         advance;
   logic                         is_last;
   logic [pif_pkg::LEN_BITS-1:0] dig_pos;
   logic [3:0]                   digit;
   logic [7:0]                   digit_char;
   logic [7:0]                   cur_char;
   logic [pif_pkg::CHARS_BITS-1:0] chars_out;

   // A new character moves into the output register when it is empty or draining.
   assign advance = job_valid && (!valid_ff || rsp_ready);
   assign is_last = (pos_ff == (job.e_total - pif_pkg::LEN_BITS'(1)));
   assign pop     = advance && is_last;

   // Digits are stored least significant first; the text shows them most significant first.
   assign dig_pos = job.e_dig - pif_pkg::LEN_BITS'(1) - pos_ff;
   assign digit   = job.digits[{dig_pos[pif_pkg::ND_BITS-1:0], 2'b00} +: 4];

   always_comb begin
      if (digit < 4'd10) begin
         digit_char = pif_pkg::CHAR_ZERO + 8'(digit);
      end else if (job.upper) begin
         digit_char = pif_pkg::HEX_UPPER_BIAS + 8'(digit);
      end else begin
         digit_char = pif_pkg::HEX_LOWER_BIAS + 8'(digit);
      end
   end

   // Pick the character by the region that the current position falls in.
   always_comb begin
      if (pos_ff < job.e_lead) begin
         cur_char = pif_pkg::CHAR_SPACE;
      end else if (pos_ff < job.e_pfx) begin
         if (pos_ff == job.e_lead) begin
            cur_char = pif_pkg::CHAR_ZERO;
         end else begin
            cur_char = job.upper ? pif_pkg::CHAR_X_UPPER : pif_pkg::CHAR_X_LOWER;
         end
      end else if (pos_ff < job.e_sign) begin
         cur_char = job.sign_char;
      end else if (pos_ff < job.e_prec) begin
         cur_char = pif_pkg::CHAR_ZERO;
      end else if (pos_ff < job.e_dig) begin
         cur_char = digit_char;
      end else begin
         cur_char = pif_pkg::CHAR_SPACE;
      end
   end

   // The running total is reported after counting the current character.
   assign total_in = advance ? (total_ff + COUNT_BITS'(1)) : total_ff;

   generate
      if (COUNT_BITS >= pif_pkg::CHARS_BITS) begin : g_wide_count
         assign chars_out = total_in[pif_pkg::CHARS_BITS-1:0];
      end else begin : g_narrow_count
         assign chars_out = {{(pif_pkg::CHARS_BITS-COUNT_BITS){1'b0}}, total_in};
      end
   endgenerate

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         pos_in                = is_last ? '0 : (pos_ff + pif_pkg::LEN_BITS'(1));
         valid_in              = 1'b1;
         data_in.out_char      = cur_char;
         data_in.last_char     = is_last;
         data_in.chars_so_far  = chars_out;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/printf_integer_formatter_core.sv
// Top level of the printf-style integer formatter (%d, %i, %u, %x, %X).
//
//   Channel   Direction  Payload                 Meaning
//   req_      in         pif_pkg::pif_req_type   one value with its flags
//   rsp_      out        pif_pkg::pif_rsp_type   one character of the text
//
// The front end takes one value at a time: it accepts the value, runs the
// binary-to-BCD conversion for decimal (none for hex), then counts digits,
// sizes the precision zeros, sizes the padding and queues the job. The back
// end emits one character per cycle while the response side is ready, from
// the head of a two-entry queue, so the next value converts while the
// previous one is still being emitted. Reset clears the queue, the sequencer
// and the running total. A stalled response holds the back end; the front
// end waits in its hand-over state only while the queue is full.
module printf_integer_formatter_core #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pif_pkg::pif_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pif_pkg::pif_rsp_type rsp_data
);

   pif_pkg::pif_job_type new_job;
   pif_pkg::pif_job_type head_job;
   logic                 job_push;
   logic                 job_pop;
   logic                 queue_full;
   logic                 queue_valid;

   // Converter and layout.
   pif_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (job_push),
      .full      (queue_full),
      .job       (new_job)
   );

   // Job queue.
   pif_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (new_job),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (queue_valid),
      .head      (head_job)
   );

   // Character emitter.
   pif_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (head_job),
      .pop       (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/printf_integer_formatter_core_tb.sv
// Self-checking testbench for the printf-style integer formatter core.
`timescale 1ns / 1ps

module printf_integer_formatter_core_tb;

   // Spare conversion code; the block formats it as decimal.
   localparam logic [1:0] CONV_UNUSED = 2'd3;

   // Flag sets, packed in request field order.
   localparam logic [5:0] FLAG_NONE  = 6'b000000;
   localparam logic [5:0] FLAG_LEFT  = 6'b100000;
   localparam logic [5:0] FLAG_ZERO  = 6'b010000;
   localparam logic [5:0] FLAG_DOT   = 6'b001000;
   localparam logic [5:0] FLAG_PLUS  = 6'b000100;
   localparam logic [5:0] FLAG_SPACE = 6'b000010;
   localparam logic [5:0] FLAG_ALT   = 6'b000001;

   localparam int unsigned MAX_IDLE     = 5;
   localparam int unsigned DRAIN_CYCLES = 200000;
   localparam int unsigned TAIL_CYCLES  = 150;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   pif_pkg::pif_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   pif_pkg::pif_rsp_type rsp_data;

   // Predicted characters waiting for their transfer, oldest first.
   pif_pkg::pif_rsp_type expected_chars[$];
   logic [31:0] char_total = '0;
   int unsigned error_count = 0;
   int unsigned values_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned ready_wait = 0;
   logic        no_idle = 1'b0;

   printf_integer_formatter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("Mismatch at %0t on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
   endtask

   // Works out the text of one value and queues its characters.
   function automatic void predict_text(input pif_pkg::pif_req_type item);
      logic [63:0] mag;
      logic [63:0] rest;
      logic [63:0] base;
      logic [63:0] rem;
      logic [3:0]  digit_buf [pif_pkg::NUM_DIGITS];
      logic [7:0]  sign_char;
      logic [7:0]  ch;
      logic        neg;
      logic        hex;
      logic        upper;
      logic        prefix;
      logic        zero_fill;
      int unsigned nd;
      int unsigned width;
      int unsigned prec;
      int unsigned zeros;
      int unsigned body;
      int unsigned pad;
      pif_pkg::pif_rsp_type text[$];

      neg   = item.value[63];
      mag   = neg ? (64'd0 - item.value) : item.value;
      hex   = (item.conversion == pif_pkg::CONV_HEX_LOWER) ||
              (item.conversion == pif_pkg::CONV_HEX_UPPER);
      upper = (item.conversion == pif_pkg::CONV_HEX_UPPER);
      base  = hex ? 64'd16 : 64'd10;
      width = (item.field_width > pif_pkg::MAX_FIELD) ? pif_pkg::MAX_FIELD : item.field_width;
      prec  = !item.has_precision ? 0 :
              (item.precision_digits > pif_pkg::MAX_FIELD) ? pif_pkg::MAX_FIELD :
              item.precision_digits;

      // Plus beats space; a negative value always shows its minus.
      sign_char = neg ? pif_pkg::CHAR_MINUS : item.force_plus ? pif_pkg::CHAR_PLUS :
                  item.space_sign ? pif_pkg::CHAR_SPACE : 8'h00;
      prefix    = hex && item.alt_prefix && (mag != 0);
      zero_fill = !item.left_justify && item.zero_pad && !item.has_precision;

      // Digits, least significant first; zero still yields one digit.
      nd   = 0;
      rest = mag;
      do begin
         rem = rest % base;
         digit_buf[nd] = rem[3:0];
         rest = rest / base;
         nd++;
      end while (rest != 0 && nd < pif_pkg::NUM_DIGITS);

      zeros = (prec > nd) ? prec - nd : 0;
      body  = nd + zeros + ((sign_char != 8'h00) ? 1 : 0) + (prefix ? 2 : 0);
      pad   = (width > body) ? width - body : 0;

      // Lay the text out region by region.
      if (!item.left_justify && !zero_fill)
         repeat (pad) text.push_back('{pif_pkg::CHAR_SPACE, 1'b0, 32'd0});
      if (prefix) begin
         text.push_back('{pif_pkg::CHAR_ZERO, 1'b0, 32'd0});
         text.push_back('{upper ? pif_pkg::CHAR_X_UPPER : pif_pkg::CHAR_X_LOWER,
                          1'b0, 32'd0});
      end
      if (sign_char != 8'h00)
         text.push_back('{sign_char, 1'b0, 32'd0});
      if (zero_fill)
         repeat (pad) text.push_back('{pif_pkg::CHAR_ZERO, 1'b0, 32'd0});
      repeat (zeros) text.push_back('{pif_pkg::CHAR_ZERO, 1'b0, 32'd0});
      for (int k = nd - 1; k >= 0; k--) begin
         if (digit_buf[k] < 4'd10)
            ch = pif_pkg::CHAR_ZERO + 8'(digit_buf[k]);
         else
            ch = (upper ? pif_pkg::HEX_UPPER_BIAS : pif_pkg::HEX_LOWER_BIAS) +
                 8'(digit_buf[k]);
         text.push_back('{ch, 1'b0, 32'd0});
      end
      if (item.left_justify)
         repeat (pad) text.push_back('{pif_pkg::CHAR_SPACE, 1'b0, 32'd0});

      // Running total after each character, and the end marker.
      foreach (text[k]) begin
         char_total = char_total + 32'd1;
         text[k].chars_so_far = char_total;
      end
      text[text.size() - 1].last_char = 1'b1;
      foreach (text[k]) expected_chars.push_back(text[k]);
   endfunction

   function automatic pif_pkg::pif_req_type make_request(input logic [63:0] value,
                                                         input logic [1:0] conv,
                                                         input logic [5:0] flags,
                                                         input logic [5:0] width,
                                                         input logic [5:0] prec);
      pif_pkg::pif_req_type item;
      item.value            = value;
      item.conversion       = conv;
      {item.left_justify, item.zero_pad, item.has_precision,
       item.force_plus, item.space_sign, item.alt_prefix} = flags;
      item.field_width      = width;
      item.precision_digits = prec;
      return item;
   endfunction

   // Sends one value after a random gap and predicts its text on transfer.
   // Valid stays high after the transfer so back-to-back values never drop it.
   task automatic send_value(input pif_pkg::pif_req_type item);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_text(item);
      values_sent++;
   endtask

   // Stops sending and waits until every predicted character has arrived.
   task automatic drain_text();
      int unsigned guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_chars.size() != 0 && guard < DRAIN_CYCLES) begin
         @(posedge clock);
         guard++;
      end
      if (expected_chars.size() != 0) begin
         error_count++;
         $display("%0d predicted characters never arrived", expected_chars.size());
      end
   endtask

   // Response side: per-character stall and field-by-field compare.
   always @(posedge clock) begin
      int unsigned w;
      pif_pkg::pif_rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected out_char", 32'd0, 32'(rsp_data.out_char));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.out_char !== want.out_char)
               report_mismatch("out_char", 32'(want.out_char), 32'(rsp_data.out_char));
            if (rsp_data.last_char !== want.last_char)
               report_mismatch("last_char", 32'(want.last_char), 32'(rsp_data.last_char));
            if (rsp_data.chars_so_far !== want.chars_so_far)
               report_mismatch("chars_so_far", want.chars_so_far, rsp_data.chars_so_far);
         end
         w = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (w != 0) begin
            rsp_ready  <= 1'b0;
            ready_wait <= w - 1;
         end
      end else if (!rsp_ready) begin
         if (ready_wait == 0)
            rsp_ready <= 1'b1;
         else
            ready_wait <= ready_wait - 1;
      end
   end

   // Random value drawn from several shapes so boundaries show up often.
   function automatic logic [63:0] pick_value();
      logic [31:0] r;
      logic [63:0] p;
      r = $urandom;
      case ($urandom_range(0, 6))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 1000));
         2: return 64'd0 - 64'($urandom_range(1, 1000));
         3: return {{32{r[31]}}, r};
         4: begin
            p = 64'd1 << $urandom_range(0, 63);
            return r[0] ? p - 64'd1 : p;
         end
         5: begin
            p = 64'd1;
            repeat ($urandom_range(0, 18)) p = p * 64'd10;
            p = p - 64'($urandom_range(0, 1));
            return r[1] ? 64'd0 - p : p;
         end
         default: begin
            case (r[1:0])
               2'd0: return 64'h8000_0000_0000_0000;
               2'd1: return 64'h7FFF_FFFF_FFFF_FFFF;
               2'd2: return 64'hFFFF_FFFF_FFFF_FFFF;
               default: return 64'd0;
            endcase
         end
      endcase
   endfunction

   // Widths and precisions: mostly short, some long, a few past saturation.
   function automatic logic [5:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) return 6'($urandom_range(0, 24));
      if (r < 9) return 6'($urandom_range(25, 56));
      return 6'($urandom_range(57, 63));
   endfunction

   // Zero in its special forms.
   task automatic test_zero_value();
      send_value(make_request(64'd0, pif_pkg::CONV_DEC, FLAG_NONE, 6'd0, 6'd0));
      send_value(make_request(64'd0, pif_pkg::CONV_DEC, FLAG_DOT, 6'd0, 6'd0));
      send_value(make_request(64'd0, pif_pkg::CONV_HEX_LOWER, FLAG_ALT, 6'd5, 6'd0));
      send_value(make_request(64'd0, pif_pkg::CONV_HEX_UPPER, FLAG_ALT | FLAG_DOT,
                              6'd0, 6'd4));
      drain_text();
   endtask

   // Largest and smallest values in decimal, smallest and all-ones in hex, and the spare code.
   task automatic test_value_extremes();
      send_value(make_request(64'h7FFF_FFFF_FFFF_FFFF, pif_pkg::CONV_DEC, FLAG_NONE,
                              6'd0, 6'd0));
      send_value(make_request(64'h8000_0000_0000_0000, pif_pkg::CONV_DEC, FLAG_NONE,
                              6'd0, 6'd0));
      send_value(make_request(64'h8000_0000_0000_0000, pif_pkg::CONV_HEX_LOWER, FLAG_ALT,
                              6'd30, 6'd0));
      send_value(make_request(64'hFFFF_FFFF_FFFF_FFFF, pif_pkg::CONV_HEX_UPPER, FLAG_ALT,
                              6'd0, 6'd0));
      send_value(make_request(64'h0000_0000_00AB_CDEF, pif_pkg::CONV_HEX_UPPER, FLAG_NONE,
                              6'd0, 6'd0));
      send_value(make_request(64'd12345, CONV_UNUSED, FLAG_PLUS, 6'd8, 6'd0));
      drain_text();
   endtask

   // Sign selection: plus, space, both, and on a negative value.
   task automatic test_sign_flags();
      send_value(make_request(64'd42, pif_pkg::CONV_DEC, FLAG_PLUS | FLAG_SPACE,
                              6'd0, 6'd0));
      send_value(make_request(64'd42, pif_pkg::CONV_DEC, FLAG_SPACE, 6'd0, 6'd0));
      send_value(make_request(-64'sd42, pif_pkg::CONV_DEC, FLAG_PLUS | FLAG_SPACE,
                              6'd0, 6'd0));
      send_value(make_request(64'hDEAD_BEEF, pif_pkg::CONV_HEX_LOWER,
                              FLAG_ALT | FLAG_ZERO | FLAG_PLUS, 6'd20, 6'd0));
      drain_text();
   endtask

   // Padding rules: precision without the dot, left with zero, zero with dot.
   task automatic test_padding_rules();
      send_value(make_request(64'd7, pif_pkg::CONV_DEC, FLAG_NONE, 6'd3, 6'd40));
      send_value(make_request(-64'sd99, pif_pkg::CONV_DEC, FLAG_LEFT | FLAG_ZERO,
                              6'd30, 6'd0));
      send_value(make_request(64'd99, pif_pkg::CONV_DEC, FLAG_ZERO | FLAG_DOT,
                              6'd12, 6'd5));
      send_value(make_request(64'd5, pif_pkg::CONV_DEC, FLAG_LEFT | FLAG_PLUS,
                              6'd56, 6'd0));
      send_value(make_request(-64'sd1, pif_pkg::CONV_DEC, FLAG_ZERO, 6'd56, 6'd0));
      drain_text();
   endtask

   // Width and precision past the maximum, including the longest text.
   task automatic test_field_saturation();
      send_value(make_request(64'd1, pif_pkg::CONV_DEC, FLAG_NONE, 6'd63, 6'd0));
      send_value(make_request(-64'sd255, pif_pkg::CONV_HEX_UPPER, FLAG_ALT | FLAG_DOT,
                              6'd63, 6'd63));
      send_value(make_request(64'd3, pif_pkg::CONV_HEX_LOWER,
                              FLAG_LEFT | FLAG_DOT | FLAG_SPACE, 6'd57, 6'd57));
      drain_text();
   endtask

   // Random values and flags, alternating bursts with and without idling.
   task automatic test_random_formats(input int unsigned count);
      pif_pkg::pif_req_type item;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         item = make_request(pick_value(), 2'($urandom_range(0, 3)), 6'($urandom),
                             pick_length(), pick_length());
         send_value(item);
      end
      drain_text();
      no_idle = 1'b0;
   endtask

   // Hex values with short fields sent back to back with no idling on either side.
   task automatic test_back_to_back(input int unsigned count);
      pif_pkg::pif_req_type item;
      no_idle = 1'b1;
      for (int unsigned n = 0; n < count; n++) begin
         item = make_request(pick_value(),
                             n[0] ? pif_pkg::CONV_HEX_LOWER : pif_pkg::CONV_HEX_UPPER,
                             6'($urandom), 6'($urandom_range(0, 4)),
                             6'($urandom_range(0, 4)));
         send_value(item);
      end
      drain_text();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_value();
      test_value_extremes();
      test_sign_flags();
      test_padding_rules();
      test_field_saturation();
      test_random_formats(420);
      test_back_to_back(40);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Formatted %0d values into %0d checked characters.", values_sent, chars_checked);
      $display("Covered zero, extreme values, sign flags, padding, saturation and random mixes.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #4000000;
      $display("Timeout with %0d characters still predicted", expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
src/pif_pkg.sv
src/pif_front.sv
src/pif_fifo.sv
src/pif_back.sv
src/printf_integer_formatter_core.sv
dv/printf_integer_formatter_core_tb.sv
